// ===== hw/rtl/q2e_pkg.sv =====
// Shared types, constants and the arctangent table for the quaternion to
// Euler angle converter. No dependencies.
package q2e_pkg;

  localparam int CORDIC_STEPS = 14;
  localparam int TABLE_LEN    = 24;
  localparam int CORDIC_USED  = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam int SQRT_STEPS   = 29;
  localparam int LANE_W       = 36;
  localparam int ANG_W        = 28;
  localparam int SQ_W         = 58;

  localparam logic signed [ANG_W-1:0] HALF_PI_Q24 = 28'sd26353589;

  typedef struct packed {
    logic signed [LANE_W-1:0] x;
    logic signed [LANE_W-1:0] y;
    logic signed [ANG_W-1:0]  z;
    logic                     zero;
  } lane_t;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] root;
  } sqrt_t;

  function automatic logic [ANG_W-1:0] atan_q24(input logic [4:0] i);
    logic [ANG_W-1:0] v;
    case (i)
      5'd0:  v = 28'd13176795;
      5'd1:  v = 28'd7778716;
      5'd2:  v = 28'd4110060;
      5'd3:  v = 28'd2086331;
      5'd4:  v = 28'd1047214;
      5'd5:  v = 28'd524117;
      5'd6:  v = 28'd262123;
      5'd7:  v = 28'd131069;
      5'd8:  v = 28'd65536;
      5'd9:  v = 28'd32768;
      5'd10: v = 28'd16384;
      5'd11: v = 28'd8192;
      5'd12: v = 28'd4096;
      5'd13: v = 28'd2048;
      5'd14: v = 28'd1024;
      5'd15: v = 28'd512;
      5'd16: v = 28'd256;
      5'd17: v = 28'd128;
      5'd18: v = 28'd64;
      5'd19: v = 28'd32;
      5'd20: v = 28'd16;
      5'd21: v = 28'd8;
      5'd22: v = 28'd4;
      5'd23: v = 28'd2;
      default: v = 28'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/q2e_sqrt_cell.sv =====
// One bit of the integer square root: a restoring step on remainder/root.
// Depends on q2e_pkg.
module q2e_sqrt_cell (
  input  logic                 clk,
  input  logic [4:0]           bit_pos,
  input  q2e_pkg::sqrt_t       din,
  output q2e_pkg::sqrt_t       dout_r
);

  logic [q2e_pkg::SQ_W-1:0] bit_v;
  logic [q2e_pkg::SQ_W-1:0] trial;
  q2e_pkg::sqrt_t           dout_nxt;

  always_comb begin
    bit_v = q2e_pkg::SQ_W'(1) << {bit_pos, 1'b0};
    trial = din.root + bit_v;
    if (din.rem >= trial) begin
      dout_nxt.rem  = din.rem - trial;
      dout_nxt.root = (din.root >> 1) + bit_v;
    end else begin
      dout_nxt.rem  = din.rem;
      dout_nxt.root = din.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    dout_r <= dout_nxt;
  end

endmodule

// ===== hw/rtl/q2e_cordic_cell.sv =====
// One vectoring CORDIC micro-rotation on a single lane.
// Depends on q2e_pkg.
module q2e_cordic_cell (
  input  logic           clk,
  input  logic [4:0]     step,
  input  q2e_pkg::lane_t din,
  output q2e_pkg::lane_t dout_r
);

  logic signed [q2e_pkg::LANE_W-1:0] xs;
  logic signed [q2e_pkg::LANE_W-1:0] ys;
  logic signed [q2e_pkg::ANG_W-1:0]  a;
  q2e_pkg::lane_t                    dout_nxt;

  always_comb begin
    xs = din.x >>> step;
    ys = din.y >>> step;
    a  = $signed(q2e_pkg::atan_q24(step));
    dout_nxt.zero = din.zero;
    if (!din.y[q2e_pkg::LANE_W-1]) begin
      dout_nxt.x = din.x + ys;
      dout_nxt.y = din.y - xs;
      dout_nxt.z = din.z + a;
    end else begin
      dout_nxt.x = din.x - ys;
      dout_nxt.y = din.y + xs;
      dout_nxt.z = din.z - a;
    end
  end

  always_ff @(posedge clk) begin
    dout_r <= dout_nxt;
  end

endmodule

// ===== hw/rtl/quaternion_to_euler_angles.sv =====
// Top level of the quaternion to Euler angle converter.
// Depends on q2e_pkg, q2e_sqrt_cell and q2e_cordic_cell.
//
// Fully pipelined: a request is taken in every cycle (busy stays low) and its
// angles appear on the out_ ports, marked by out_valid for one cycle, after
// the product, asin-argument and sqrt-operand registers, the row of 29
// square-root cells for the pitch cosine, the row of CORDIC cells, one cell per
// iteration, and the output register. The receiver cannot stall, so
// results must be captured on the cycle out_valid is high.
module quaternion_to_euler_angles (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic signed [15:0] in_quat_w,
  output logic               out_valid,
  output logic signed [13:0] out_pitch_angle,
  output logic signed [14:0] out_yaw_angle,
  output logic signed [14:0] out_roll_angle
);

  localparam int NC  = q2e_pkg::CORDIC_USED;
  localparam int NS  = q2e_pkg::SQRT_STEPS;
  localparam int LAT = 3 + NS + NC + 1;
  localparam int LW  = q2e_pkg::LANE_W;

  localparam logic signed [33:0] ONE_Q28   = 34'sd268435456;
  localparam logic [56:0]        ONE_SQ    = 57'd1 << 56;
  localparam logic signed [15:0] PITCH_MAX = 16'sd6434;
  localparam logic signed [15:0] ANGLE_MAX = 16'sd12868;

  typedef struct packed {
    q2e_pkg::lane_t     yaw;
    q2e_pkg::lane_t     roll;
    logic signed [29:0] s;
  } dly_t;

  // Move vectors in the left half plane into the right one by +-pi/2.
  function automatic q2e_pkg::lane_t prerot(input logic signed [33:0] y,
                                            input logic signed [33:0] x);
    q2e_pkg::lane_t l;
    l.zero = (x == 34'sd0) && (y == 34'sd0);
    if (x < 0) begin
      if (y >= 0) begin
        l.x = LW'(y);
        l.y = -LW'(x);
        l.z = q2e_pkg::HALF_PI_Q24;
      end else begin
        l.x = -LW'(y);
        l.y = LW'(x);
        l.z = -q2e_pkg::HALF_PI_Q24;
      end
    end else begin
      l.x = LW'(x);
      l.y = LW'(y);
      l.z = '0;
    end
    return l;
  endfunction

  // Round to Q12 and clamp to +-lim.
  function automatic logic signed [15:0] to_q12(input q2e_pkg::lane_t l,
                                                input logic signed [15:0] lim);
    logic signed [q2e_pkg::ANG_W-1:0] zz;
    logic signed [15:0]               r;
    zz = l.zero ? '0 : l.z;
    r  = 16'((zz + 28'sd2048) >>> 12);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  logic [LAT-1:0] vld_r;

  // Stage 1: all component products.
  logic signed [31:0] p_wx_r, p_yz_r, p_xz_r, p_wy_r, p_xy_r, p_wz_r;
  logic signed [31:0] p_xx_r, p_yy_r, p_zz_r, p_ww_r;

  // Stage 2: asin argument and the two atan2 operand pairs.
  logic signed [33:0] s_diff, s_raw;
  logic signed [29:0] s_r;
  logic signed [33:0] yaw_y_r, yaw_x_r, roll_y_r, roll_x_r;

  // Stage 3: sqrt operand and pre-rotated yaw/roll lanes.
  logic signed [59:0] s_sq;
  q2e_pkg::sqrt_t     sq_st [NS+1];
  dly_t               dl_r  [NS+1];

  q2e_pkg::lane_t     pl    [NC+1];
  q2e_pkg::lane_t     yl    [NC+1];
  q2e_pkg::lane_t     rl    [NC+1];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    p_wx_r <= in_quat_w * in_quat_x;
    p_yz_r <= in_quat_y * in_quat_z;
    p_xz_r <= in_quat_x * in_quat_z;
    p_wy_r <= in_quat_w * in_quat_y;
    p_xy_r <= in_quat_x * in_quat_y;
    p_wz_r <= in_quat_w * in_quat_z;
    p_xx_r <= in_quat_x * in_quat_x;
    p_yy_r <= in_quat_y * in_quat_y;
    p_zz_r <= in_quat_z * in_quat_z;
    p_ww_r <= in_quat_w * in_quat_w;
  end

  always_comb begin
    s_diff = 34'(p_wx_r) - 34'(p_yz_r);
    s_raw  = s_diff <<< 1;
  end

  // Saturate the asin argument to [-1, 1].
  always_ff @(posedge clk) begin
    if (s_raw > ONE_Q28) begin
      s_r <= 30'(ONE_Q28);
    end else if (s_raw < -ONE_Q28) begin
      s_r <= 30'(-ONE_Q28);
    end else begin
      s_r <= 30'(s_raw);
    end
    yaw_y_r  <= (34'(p_xz_r) + 34'(p_wy_r)) <<< 1;
    yaw_x_r  <= 34'(p_ww_r) + 34'(p_zz_r) - 34'(p_xx_r) - 34'(p_yy_r);
    roll_y_r <= (34'(p_xy_r) + 34'(p_wz_r)) <<< 1;
    roll_x_r <= 34'(p_ww_r) + 34'(p_yy_r) - 34'(p_xx_r) - 34'(p_zz_r);
  end

  assign s_sq = s_r * s_r;

  always_ff @(posedge clk) begin
    sq_st[0].rem  <= q2e_pkg::SQ_W'(ONE_SQ - 57'(s_sq));
    sq_st[0].root <= '0;
    dl_r[0].yaw   <= prerot(yaw_y_r, yaw_x_r);
    dl_r[0].roll  <= prerot(roll_y_r, roll_x_r);
    dl_r[0].s     <= s_r;
  end

  // Square-root row, highest bit first; yaw/roll and s ride alongside.
  for (genvar i = 0; i < NS; i++) begin : g_sqrt
    q2e_sqrt_cell u_cell (
      .clk     (clk),
      .bit_pos (5'(NS - 1 - i)),
      .din     (sq_st[i]),
      .dout_r  (sq_st[i+1])
    );
    always_ff @(posedge clk) begin
      dl_r[i+1] <= dl_r[i];
    end
  end

  // Pitch vector: cosine is never negative, so no pre-rotation.
  always_comb begin
    pl[0].x    = LW'({1'b0, sq_st[NS].root[28:0]});
    pl[0].y    = LW'(dl_r[NS].s);
    pl[0].z    = '0;
    pl[0].zero = (dl_r[NS].s == 30'sd0) && (sq_st[NS].root[28:0] == 29'd0);
    yl[0]      = dl_r[NS].yaw;
    rl[0]      = dl_r[NS].roll;
  end

  for (genvar j = 0; j < NC; j++) begin : g_cordic
    q2e_cordic_cell u_pitch (.clk(clk), .step(5'(j)), .din(pl[j]), .dout_r(pl[j+1]));
    q2e_cordic_cell u_yaw   (.clk(clk), .step(5'(j)), .din(yl[j]), .dout_r(yl[j+1]));
    q2e_cordic_cell u_roll  (.clk(clk), .step(5'(j)), .din(rl[j]), .dout_r(rl[j+1]));
  end

  // Output register: round and clamp; the strobe comes from the valid shift register.
  always_ff @(posedge clk) begin
    out_pitch_angle <= 14'(to_q12(pl[NC], PITCH_MAX));
    out_yaw_angle   <= 15'(to_q12(yl[NC], ANGLE_MAX));
    out_roll_angle  <= 15'(to_q12(rl[NC], ANGLE_MAX));
  end

  assign out_valid = vld_r[LAT-1];

endmodule

// ===== hw/rtl/q2e_checker.sv =====
// Port-level checks for the quaternion to Euler angle converter, bound to
// the top level. No package dependencies.
module q2e_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic signed [13:0] out_pitch_angle,
  input logic signed [14:0] out_yaw_angle,
  input logic signed [14:0] out_roll_angle
);

  a_reset_drops_strobe: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe high after reset");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pitch_angle <= 14'sd6434) && (out_pitch_angle >= -14'sd6434))
    else $error("pitch out of range");

  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_yaw_angle <= 15'sd12868) && (out_yaw_angle >= -15'sd12868))
    else $error("yaw out of range");

  a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_roll_angle <= 15'sd12868) && (out_roll_angle >= -15'sd12868))
    else $error("roll out of range");

  a_never_busy: assert property (@(posedge clk) start |-> !busy)
    else $error("request refused");

endmodule

bind quaternion_to_euler_angles q2e_checker u_q2e_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_pitch_angle (out_pitch_angle),
  .out_yaw_angle   (out_yaw_angle),
  .out_roll_angle  (out_roll_angle)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for quaternion_to_euler_angles: drives quaternions, predicts the
// pitch, yaw and roll angles in place and checks every result. Uses q2e_pkg.
module tb_top;

  localparam int LATENCY   = 3 + q2e_pkg::SQRT_STEPS + q2e_pkg::CORDIC_STEPS + 1;
  localparam int PITCH_MAX = 6434;
  localparam int ANGLE_MAX = 12868;
  localparam longint HALF_PI = 64'sd26353589;

  typedef struct {
    logic signed [13:0] pitch;
    logic signed [14:0] yaw;
    logic signed [14:0] roll;
  } angles_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [15:0] in_quat_x;
  logic signed [15:0] in_quat_y;
  logic signed [15:0] in_quat_z;
  logic signed [15:0] in_quat_w;
  logic               out_valid;
  logic signed [13:0] out_pitch_angle;
  logic signed [14:0] out_yaw_angle;
  logic signed [14:0] out_roll_angle;

  angles_t pending_angles[$];
  int      error_count;
  int      request_count;
  int      result_count;
  int      idle_pct;

  quaternion_to_euler_angles dut (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Floor division by 2^s; arithmetic right shift of a signed longint floors.
  function automatic longint floor_div(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(input longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(root);
  endfunction

  // Vectoring CORDIC, angle in Q24 radians.
  function automatic longint vector_angle(input longint y, input longint x);
    longint acc;
    longint t;
    longint xs;
    longint ys;
    int     steps;
    acc = 0;
    steps = (q2e_pkg::CORDIC_STEPS > q2e_pkg::TABLE_LEN) ? q2e_pkg::TABLE_LEN
                                                         : q2e_pkg::CORDIC_STEPS;
    if (x == 0 && y == 0) return 0;
    // Fold the left half plane over by a quarter turn first.
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; acc = HALF_PI;
      end else begin
        t = x; x = -y; y = t; acc = -HALF_PI;
      end
    end
    for (int i = 0; i < steps; i++) begin
      xs = floor_div(x, i);
      ys = floor_div(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; acc += longint'(q2e_pkg::atan_q24(i[4:0]));
      end else begin
        x -= ys; y += xs; acc -= longint'(q2e_pkg::atan_q24(i[4:0]));
      end
    end
    return acc;
  endfunction

  function automatic longint round_q12(input longint a24, input longint lim);
    longint r;
    r = floor_div(a24 + 2048, 12);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic angles_t euler_angles(input logic signed [15:0] qx,
                                           input logic signed [15:0] qy,
                                           input logic signed [15:0] qz,
                                           input logic signed [15:0] qw);
    longint  x, y, z, w, s, c, one;
    angles_t a;
    x = longint'(qx); y = longint'(qy); z = longint'(qz); w = longint'(qw);
    one = 64'sd1 << 28;
    // Saturate the asin argument into its domain.
    s = 2 * (w * x - y * z);
    if (s > one) s = one;
    if (s < -one) s = -one;
    c = int_sqrt(longint'(one * one - s * s));
    a.pitch = 14'(round_q12(vector_angle(s, c), PITCH_MAX));
    a.yaw   = 15'(round_q12(vector_angle(2 * (x * z + w * y),
                            w * w + z * z - x * x - y * y), ANGLE_MAX));
    a.roll  = 15'(round_q12(vector_angle(2 * (x * y + w * z),
                            w * w + y * y - x * x - z * z), ANGLE_MAX));
    return a;
  endfunction

  // Hold start for one request until it is taken, then drop it unless the
  // next request follows immediately.
  task automatic send_quat(input logic signed [15:0] qx, input logic signed [15:0] qy,
                           input logic signed [15:0] qz, input logic signed [15:0] qw);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    in_quat_x <= qx;
    in_quat_y <= qy;
    in_quat_z <= qz;
    in_quat_w <= qw;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_angles.insert(pending_angles.size(), euler_angles(qx, qy, qz, qw));
    request_count++;
  endtask

  task automatic release_start();
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(9))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'sd0;
      3: return 16'($urandom);
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  // Random unit-ish quaternion: three random components, fourth sized so the
  // sum of squares lands near one.
  task automatic send_unit_quat();
    longint a, b, d, r;
    a = $signed($urandom_range(32768)) - 16384;
    b = $signed($urandom_range(32768)) - 16384;
    d = $signed($urandom_range(32768)) - 16384;
    r = (64'sd1 << 28) - a * a - b * b - d * d;
    if (r < 0) begin
      a = a / 2; b = b / 2; d = d / 2;
      r = (64'sd1 << 28) - a * a - b * b - d * d;
    end
    r = int_sqrt(r < 0 ? 0 : r);
    if ($urandom_range(1)) r = -r;
    case ($urandom_range(3))
      0: send_quat(16'(r), 16'(a), 16'(b), 16'(d));
      1: send_quat(16'(a), 16'(r), 16'(b), 16'(d));
      2: send_quat(16'(a), 16'(b), 16'(r), 16'(d));
      default: send_quat(16'(a), 16'(b), 16'(d), 16'(r));
    endcase
  endtask

  task automatic test_directed();
    idle_pct = 0;
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd16384);        // identity
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);            // yaw and roll atan2 of zero and zero
    send_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd16384);    // asin argument beyond one
    send_quat(-16'sd16384, 16'sd0, 16'sd0, 16'sd16384);   // asin argument beyond minus one
    send_quat(16'sd11585, 16'sd0, 16'sd0, 16'sd11585);    // pitch near plus a quarter turn
    send_quat(16'sd0, 16'sd16384, 16'sd0, 16'sd0);        // yaw of pi, negative x in atan2
    send_quat(16'sd0, 16'sd0, 16'sd16384, 16'sd0);        // roll of pi
    send_quat(16'sd0, 16'sd11585, 16'sd0, -16'sd11585);   // negative y with zero x in the yaw atan2
    send_quat(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
    send_quat(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384);
    send_quat(16'sh8000, 16'sd32767, 16'sh8000, 16'sd32767); // out of range components
    send_quat(16'sd32767, 16'sh8000, 16'sd32767, 16'sh8000);
    send_quat(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    send_quat(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    send_quat(16'sd1, -16'sd1, 16'sd1, -16'sd1);
    send_quat(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
    send_quat(16'sd0, 16'sd0, 16'sd16384, 16'sd16384);
    send_quat(16'sd0, 16'sd16384, 16'sd0, 16'sd16384);
    release_start();
  endtask

  task automatic test_random(input int pct, input int n);
    idle_pct = pct;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0)
        send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
      else
        send_unit_quat();
    end
    release_start();
  endtask

  // Results cannot be held off: take one every cycle out_valid is high.
  always @(posedge clk) begin
    angles_t exp_a;
    if (rst_n && out_valid) begin
      result_count++;
      if (pending_angles.size() == 0) begin
        $error("unexpected result: pitch %0d yaw %0d roll %0d",
               out_pitch_angle, out_yaw_angle, out_roll_angle);
        error_count++;
      end else begin
        exp_a = pending_angles.pop_front();
        if (out_pitch_angle !== exp_a.pitch) begin
          $error("pitch_angle expected %0d got %0d", exp_a.pitch, out_pitch_angle);
          error_count++;
        end
        if (out_yaw_angle !== exp_a.yaw) begin
          $error("yaw_angle expected %0d got %0d", exp_a.yaw, out_yaw_angle);
          error_count++;
        end
        if (out_roll_angle !== exp_a.roll) begin
          $error("roll_angle expected %0d got %0d", exp_a.roll, out_roll_angle);
          error_count++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("quaternion_to_euler_angles test failed");
    $finish;
  end

  initial begin
    error_count   = 0;
    request_count = 0;
    result_count  = 0;
    idle_pct      = 0;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_quat_x = '0;
    in_quat_y = '0;
    in_quat_z = '0;
    in_quat_w = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(0, 250);
    test_random(62, 200);
    test_random(0, 200);
    test_random(27, 200);

    while (pending_angles.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    $display("Sent %0d quaternions, checked %0d angle triples,", request_count,
             result_count);
    $display("across back-to-back and idle-gapped request phases.");
    if (error_count == 0)
      $display("quaternion_to_euler_angles test passed");
    else
      $display("quaternion_to_euler_angles test failed");
    $finish;
  end

endmodule
